// ===== hw/rtl/scan_victim_locator_dedup_unit_macros.svh =====
// Assertion macros shared by the victim locator RTL.
`ifndef SCAN_VICTIM_LOCATOR_DEDUP_UNIT_MACROS_SVH
`define SCAN_VICTIM_LOCATOR_DEDUP_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define SVL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SVL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SVL_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SVL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/svl_pkg.sv =====
// Shared types, constants and tables for the victim locator.
package svl_pkg;
    localparam int BEAMS_DEF = 720;
    localparam int IMAGE_WIDTH_DEF = 280;
    localparam int VICTIM_SLOTS_DEF = 64;

    localparam logic [1:0] FUNC_BEAM = 2'd0;
    localparam logic [1:0] FUNC_POSE = 2'd1;
    localparam logic [1:0] FUNC_DET = 2'd2;

    localparam logic [1:0] CFG_MAX_RANGE = 2'd0;
    localparam logic [1:0] CFG_MIN_VALID = 2'd1;
    localparam logic [1:0] CFG_MATCH_TOL = 2'd2;

    localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MAP, ST_SCAN_RD, ST_SCAN, ST_GAIN, ST_ROT, ST_ADD,
        ST_TAB_RD, ST_TAB, ST_APPEND, ST_OUT
    } t_state;

    typedef struct packed {
        logic map;
        logic scan_start;
        logic scan_step;
        logic gain;
        logic rot_start;
        logic rot_step;
        logic add;
        logic tab_start;
        logic tab_step;
        logic append;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic rot_done;
        logic tab_done;
        logic found;
    } t_sts;

    function automatic logic [15:0] atan_bam(input logic [3:0] i);
        logic [15:0] v;
        case (i)
            4'd0: v = 16'd8192;
            4'd1: v = 16'd4836;
            4'd2: v = 16'd2555;
            4'd3: v = 16'd1297;
            4'd4: v = 16'd651;
            4'd5: v = 16'd326;
            4'd6: v = 16'd163;
            4'd7: v = 16'd81;
            4'd8: v = 16'd41;
            4'd9: v = 16'd20;
            4'd10: v = 16'd10;
            4'd11: v = 16'd5;
            4'd12: v = 16'd3;
            4'd13: v = 16'd1;
            4'd14: v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction
endpackage

// ===== hw/rtl/svl_ctrl.sv =====
// Sequencer for detections: window scan, rotation, table walk, result.
`include "scan_victim_locator_dedup_unit_macros.svh"
module svl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  svl_pkg::t_sts  i_sts,
    input  logic           i_out_free,
    output svl_pkg::t_cmd  o_cmd,
    output logic           o_busy,
    output logic           o_load_out
);
    import svl_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_MAP;
            end
            ST_MAP: begin
                o_cmd.map = 1'b1;
                n_state = ST_SCAN_RD;
            end
            ST_SCAN_RD: begin
                o_cmd.scan_start = 1'b1;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) n_state = ST_GAIN;
            end
            ST_GAIN: begin
                o_cmd.gain = 1'b1;
                n_state = ST_ROT;
            end
            ST_ROT: begin
                o_cmd.rot_step = 1'b1;
                if (i_sts.rot_done) n_state = ST_ADD;
            end
            ST_ADD: begin
                o_cmd.add = 1'b1;
                n_state = ST_TAB_RD;
            end
            ST_TAB_RD: begin
                o_cmd.tab_start = 1'b1;
                n_state = ST_TAB;
            end
            ST_TAB: begin
                o_cmd.tab_step = 1'b1;
                if (i_sts.tab_done) n_state = ST_APPEND;
            end
            ST_APPEND: begin
                o_cmd.append = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_out_free) begin
                    o_load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        o_cmd.rot_start = o_cmd.gain;
    end

    assign o_busy = (r_state != ST_IDLE);

    `SVL_ASSERT_NEXT(a_start_maps, i_clk, i_rst_n, (r_state == ST_IDLE) && i_start,
        r_state == ST_MAP)
    `SVL_ASSERT_IMPL(a_load_in_out, i_clk, i_rst_n, o_load_out, r_state == ST_OUT)
    `SVL_ASSERT_NEXT(a_load_idle, i_clk, i_rst_n, o_load_out, r_state == ST_IDLE)
endmodule

// ===== hw/rtl/svl_datapath.sv =====
// Datapath: scan store, pose, CORDIC, victim table and match logic.
`include "scan_victim_locator_dedup_unit_macros.svh"
module svl_datapath #(
    parameter int BEAMS = svl_pkg::BEAMS_DEF,
    parameter int IMAGE_WIDTH = svl_pkg::IMAGE_WIDTH_DEF,
    parameter int VICTIM_SLOTS = svl_pkg::VICTIM_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_beam_we,
    input  logic [9:0]        i_beam_index,
    input  logic [15:0]       i_beam_range_mm,
    input  logic              i_pose_we,
    input  logic [31:0]       i_pose_x_mm,
    input  logic [31:0]       i_pose_y_mm,
    input  logic [15:0]       i_pose_yaw,
    input  logic              i_det_we,
    input  logic [8:0]        i_centroid_col,
    input  logic [8:0]        i_left_col,
    input  logic [15:0]       i_max_range_mm,
    input  logic [15:0]       i_min_valid_mm,
    input  logic [15:0]       i_match_tolerance_mm,
    input  svl_pkg::t_cmd     i_cmd,
    output svl_pkg::t_sts     o_sts,
    output logic              o_clearing,
    output logic              o_is_new_victim,
    output logic [31:0]       o_victim_x_mm,
    output logic [31:0]       o_victim_y_mm,
    output logic [15:0]       o_distance_mm,
    output logic              o_table_full
);
    import svl_pkg::*;

    localparam int BW = $clog2(BEAMS);
    localparam int VW = (VICTIM_SLOTS > 1) ? $clog2(VICTIM_SLOTS) : 1;
    localparam int CW = $clog2(VICTIM_SLOTS + 1);
    localparam longint MAP_NUM = 6 * BEAMS;
    localparam longint MAP_DEN = 25 * IMAGE_WIDTH;
    localparam int HALF_IMG = IMAGE_WIDTH / 2;
    localparam int HALF_BEAMS = BEAMS / 2;
    // beam = floor((col*NUM + ADD0) / DEN) - OFF + BEAMS/2, via reciprocal multiply
    localparam longint MAP_SH = 27;
    localparam longint MAP_OFF = (longint'(HALF_IMG) * MAP_NUM + MAP_DEN - 1) / MAP_DEN;
    localparam longint MAP_ADD0 = MAP_OFF * MAP_DEN - longint'(HALF_IMG) * MAP_NUM;
    localparam longint MAP_MUL = ((MAP_NUM << MAP_SH) + MAP_DEN - 1) / MAP_DEN;
    localparam longint MAP_ADD = ((MAP_ADD0 << MAP_SH) + MAP_DEN - 1) / MAP_DEN;

    // scan store, zeroed by a clearing pass over all BEAMS entries after reset
    logic [15:0]      r_scan_mem [BEAMS];
    logic [15:0]      r_scan_rd;
    logic [BW-1:0]    r_rd_addr;
    logic [BW-1:0]    r_clr_addr;
    logic             r_clr_act;

    logic signed [31:0] r_rx, r_ry;
    logic signed [15:0] r_yaw;
    logic [8:0]  r_ccol, r_lcol;
    logic [BW-1:0] r_lb, r_mb, r_idx;
    logic        r_empty;
    logic [15:0] r_best;

    logic signed [63:0] r_cx, r_cy;
    logic signed [16:0] r_cz;
    logic [3:0]         r_it;
    logic signed [31:0] r_vx, r_vy;

    logic [31:0]   r_tab_mem [VICTIM_SLOTS];
    logic [31:0]   r_tab_memy [VICTIM_SLOTS];
    logic [31:0]   r_tx, r_ty;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_tidx;
    logic          r_found;
    logic          r_full;

    function automatic logic [BW-1:0] col_to_beam(input logic [8:0] col);
        logic [47:0]        prod;
        logic signed [47:0] b;
        prod = 48'(col) * 48'(MAP_MUL) + 48'(MAP_ADD);
        b = $signed(prod >> MAP_SH) + 48'(longint'(HALF_BEAMS) - MAP_OFF);
        if (b < 0) b = '0;
        if (b > 48'(BEAMS - 1)) b = 48'(BEAMS - 1);
        return b[BW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (r_clr_act) begin
            r_scan_mem[r_clr_addr] <= '0;
        end else if (i_beam_we && ({1'b0, i_beam_index} < 11'(BEAMS))) begin
            r_scan_mem[i_beam_index[BW-1:0]] <= i_beam_range_mm;
        end
        r_scan_rd <= r_scan_mem[r_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_act <= 1'b1;
            r_clr_addr <= '0;
            r_rx <= '0;
            r_ry <= '0;
            r_yaw <= '0;
            r_count <= '0;
        end else begin
            if (r_clr_act) begin
                if (r_clr_addr == BW'(BEAMS - 1)) r_clr_act <= 1'b0;
                else r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_pose_we) begin
                r_rx <= i_pose_x_mm;
                r_ry <= i_pose_y_mm;
                r_yaw <= i_pose_yaw;
            end
            if (i_cmd.append && !r_found && (r_count < CW'(VICTIM_SLOTS))) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    assign o_clearing = r_clr_act;

    // window scan: address runs one ahead of compare
    logic [15:0] w_r;
    assign w_r = r_scan_rd;

    always_ff @(posedge i_clk) begin
        if (i_det_we) begin
            r_ccol <= i_centroid_col;
            r_lcol <= i_left_col;
        end
        if (i_cmd.map) begin
            r_mb <= col_to_beam(r_ccol);
            r_lb <= col_to_beam(r_lcol);
            r_rd_addr <= col_to_beam(r_lcol);
            r_best <= i_max_range_mm;
        end
        if (i_cmd.scan_start) begin
            r_empty <= (r_lb > r_mb);
            r_idx <= r_lb;
            if (r_rd_addr != r_mb) r_rd_addr <= r_rd_addr + 1'b1;
        end
        if (i_cmd.scan_step) begin
            if (!r_empty && (w_r <= r_best) && (w_r >= i_min_valid_mm)) r_best <= w_r;
            r_idx <= r_idx + 1'b1;
            if (r_rd_addr != r_mb) r_rd_addr <= r_rd_addr + 1'b1;
        end
    end

    assign o_sts.scan_done = r_empty || (r_idx == r_mb);

    // CORDIC, one iteration per cycle
    logic signed [47:0] w_gain;
    logic signed [63:0] w_x0;
    logic signed [63:0] w_xs, w_ys;
    assign w_gain = $signed({32'd0, r_best}) * $signed({18'd0, CORDIC_GAIN_Q30});
    assign w_x0 = 64'(w_gain >>> 14);
    assign w_xs = r_cx >>> r_it;
    assign w_ys = r_cy >>> r_it;

    always_ff @(posedge i_clk) begin
        if (i_cmd.gain) begin
            r_cy <= '0;
            r_it <= '0;
            if (r_yaw > 16'sd16384) begin
                r_cz <= 17'(r_yaw) - 17'sd32768;
                r_cx <= -w_x0;
            end else if (r_yaw < -16'sd16384) begin
                r_cz <= 17'(r_yaw) + 17'sd32768;
                r_cx <= -w_x0;
            end else begin
                r_cz <= 17'(r_yaw);
                r_cx <= w_x0;
            end
        end
        if (i_cmd.rot_step) begin
            if (r_cz >= 0) begin
                r_cx <= r_cx - w_ys;
                r_cy <= r_cy + w_xs;
                r_cz <= r_cz - $signed({1'b0, atan_bam(r_it)});
            end else begin
                r_cx <= r_cx + w_ys;
                r_cy <= r_cy - w_xs;
                r_cz <= r_cz + $signed({1'b0, atan_bam(r_it)});
            end
            r_it <= r_it + 1'b1;
        end
        if (i_cmd.add) begin
            r_vx <= r_rx + 32'((r_cx + 64'sd32768) >>> 16);
            r_vy <= r_ry + 32'((r_cy + 64'sd32768) >>> 16);
        end
    end

    assign o_sts.rot_done = (r_it == 4'd15);

    // victim table walk: read one entry a cycle, entry 0 fetched at start
    logic [VW-1:0] w_taddr;
    assign w_taddr = i_cmd.tab_start ? '0 : r_tidx[VW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.append && !r_found && (r_count < CW'(VICTIM_SLOTS))) begin
            r_tab_mem[r_count[VW-1:0]] <= r_vx;
            r_tab_memy[r_count[VW-1:0]] <= r_vy;
        end
        r_tx <= r_tab_mem[w_taddr];
        r_ty <= r_tab_memy[w_taddr];
    end

    logic signed [32:0] w_ex, w_ey, w_tol;
    logic               w_hit;
    logic [CW-1:0]      r_cidx;
    assign w_ex = 33'(r_vx) - 33'($signed(r_tx));
    assign w_ey = 33'(r_vy) - 33'($signed(r_ty));
    assign w_tol = $signed({17'd0, i_match_tolerance_mm});
    assign w_hit = (w_ex < w_tol) && (w_ex > -w_tol) && (w_ey < w_tol) && (w_ey > -w_tol);

    always_ff @(posedge i_clk) begin
        if (i_cmd.tab_start) begin
            r_found <= 1'b0;
            r_tidx <= '0;
            r_cidx <= '0;
            if (r_count != 0) r_tidx <= CW'(1);
        end
        if (i_cmd.tab_step) begin
            if (r_cidx < r_count && w_hit) r_found <= 1'b1;
            r_cidx <= r_cidx + 1'b1;
            if (r_tidx < CW'(VICTIM_SLOTS - 1)) r_tidx <= r_tidx + 1'b1;
        end
        if (i_cmd.append) begin
            r_full <= !r_found && (r_count == CW'(VICTIM_SLOTS));
        end
    end

    assign o_sts.tab_done = r_found || (r_cidx >= r_count) ||
        (i_cmd.tab_step && r_cidx < r_count && w_hit);
    assign o_sts.found = r_found;

    assign o_is_new_victim = !r_found;
    assign o_victim_x_mm = r_vx;
    assign o_victim_y_mm = r_vy;
    assign o_distance_mm = r_best;
    assign o_table_full = r_full;

    `SVL_ASSERT_IMPL(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CW'(VICTIM_SLOTS))
    `SVL_ASSERT_NEXT(a_rot_last, i_clk, i_rst_n, i_cmd.gain, r_it == 4'd0)
    `SVL_ASSERT_IMPL(a_cmd_excl, i_clk, i_rst_n, 1'b1,
        $onehot0({i_cmd.map, i_cmd.scan_step, i_cmd.rot_step, i_cmd.tab_step, i_cmd.append}))
endmodule

// ===== hw/rtl/scan_victim_locator_dedup_unit.sv =====
// Top level of the scan victim locator with de-duplication.
// Usage:
//  Input stream s_axis: tdata carries func, beam_index, beam_range_mm, pose_x_mm,
//  pose_y_mm, pose_yaw, centroid_col, left_col; tuser carries is_human.
//  Beam loads, pose updates, unused codes and non-human detections do not make
//  the block busy and give no transaction out.
//  A human detection walks the beam window (one beam a cycle), runs 16 CORDIC
//  iterations and walks the victim table (one entry a cycle up to the first
//  match), then loads the result into the output register. s_axis_tready is
//  low meanwhile and rises in the same cycle as m_axis_tvalid, so the next
//  item can be taken while the result waits.
//  Output stream m_axis: tdata carries is_new_victim, victim_x_mm, victim_y_mm,
//  distance_mm, table_full, held in an output register until taken.
//  A stalled receiver holds the detection result; beam and pose items still flow
//  until the next detection reaches the output stage, which then waits.
//  Configuration: i_cfg_we, i_cfg_index, i_cfg_data; write while idle.
//  Reset (synchronous, active low) clears pose, victim count and registers to
//  their defaults; the scan store is then zeroed over all BEAMS entries (720 by
//  default) with s_axis_tready low.
module scan_victim_locator_dedup_unit #(
    parameter int BEAMS = svl_pkg::BEAMS_DEF,
    parameter int IMAGE_WIDTH = svl_pkg::IMAGE_WIDTH_DEF,
    parameter int VICTIM_SLOTS = svl_pkg::VICTIM_SLOTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // func[1:0], beam_index[11:2], beam_range_mm[27:12], pose_x_mm[59:28],
    // pose_y_mm[91:60], pose_yaw[107:92], centroid_col[116:108], left_col[125:117]
    input  logic [127:0] s_axis_tdata,
    // is_human
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // is_new_victim[0], victim_x_mm[32:1], victim_y_mm[64:33], distance_mm[80:65],
    // table_full[81]
    output logic [87:0]  m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);
    import svl_pkg::*;

    logic [1:0]  w_func;
    logic        w_acc;
    logic        w_busy, w_load;
    logic        w_clr;
    t_cmd        w_cmd;
    t_sts        w_sts;
    logic [15:0] r_max, r_min, r_tol;
    logic        r_mvalid;
    logic [87:0] r_mdata;
    logic        w_nv, w_tf;
    logic [31:0] w_vx, w_vy;
    logic [15:0] w_dist;

    assign w_func = s_axis_tdata[1:0];
    assign s_axis_tready = !w_busy && !w_clr;
    assign w_acc = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= 16'd30000;
            r_min <= 16'd1000;
            r_tol <= 16'd500;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_RANGE: r_max <= i_cfg_data;
                CFG_MIN_VALID: r_min <= i_cfg_data;
                CFG_MATCH_TOL: r_tol <= i_cfg_data;
                default: ;
            endcase
        end
    end

    svl_ctrl u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_acc && (w_func == FUNC_DET) && s_axis_tuser),
        .i_sts(w_sts),
        .i_out_free(!r_mvalid || m_axis_tready),
        .o_cmd(w_cmd),
        .o_busy(w_busy),
        .o_load_out(w_load)
    );

    svl_datapath #(
        .BEAMS(BEAMS), .IMAGE_WIDTH(IMAGE_WIDTH), .VICTIM_SLOTS(VICTIM_SLOTS)
    ) u_dp (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_beam_we(w_acc && (w_func == FUNC_BEAM)),
        .i_beam_index(s_axis_tdata[11:2]),
        .i_beam_range_mm(s_axis_tdata[27:12]),
        .i_pose_we(w_acc && (w_func == FUNC_POSE)),
        .i_pose_x_mm(s_axis_tdata[59:28]),
        .i_pose_y_mm(s_axis_tdata[91:60]),
        .i_pose_yaw(s_axis_tdata[107:92]),
        .i_det_we(w_acc && (w_func == FUNC_DET)),
        .i_centroid_col(s_axis_tdata[116:108]),
        .i_left_col(s_axis_tdata[125:117]),
        .i_max_range_mm(r_max),
        .i_min_valid_mm(r_min),
        .i_match_tolerance_mm(r_tol),
        .i_cmd(w_cmd),
        .o_sts(w_sts),
        .o_clearing(w_clr),
        .o_is_new_victim(w_nv),
        .o_victim_x_mm(w_vx),
        .o_victim_y_mm(w_vy),
        .o_distance_mm(w_dist),
        .o_table_full(w_tf)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (w_load) begin
            r_mvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_mvalid <= 1'b0;
        end
        if (w_load) begin
            r_mdata <= {6'd0, w_tf, w_dist, w_vy, w_vx, w_nv};
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata = r_mdata;
endmodule
